// ===== design/gha_pkg.sv =====
// Shared types and codes of the generational handle allocator.
`timescale 1ns / 1ps
package gha_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STALE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd3;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } gha_cmd_t;

endpackage

// ===== design/gha_req_if.sv =====
// Request channel: command and handle toward the allocator.
`timescale 1ns / 1ps
interface gha_req_if #(
  parameter int SLOT_W = 6,
  parameter int GEN_W  = 16
);
  import gha_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SLOT_W-1:0]   handle_slot;
  logic [GEN_W-1:0]    handle_generation;
  logic                in_use;

  modport source (output valid, cmd, handle_slot, handle_generation, in_use, input ready);
  modport sink   (input valid, cmd, handle_slot, handle_generation, in_use, output ready);
endinterface

// ===== design/gha_rsp_if.sv =====
// Response channel: status and handle from the allocator.
`timescale 1ns / 1ps
interface gha_rsp_if #(
  parameter int SLOT_W = 6,
  parameter int GEN_W  = 16
);
  import gha_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   out_slot;
  logic [GEN_W-1:0]    out_generation;

  modport source (output valid, status, out_slot, out_generation, input ready);
  modport sink   (input valid, status, out_slot, out_generation, output ready);
endinterface

// ===== design/generational_handle_allocator.sv =====
// Top level of the generational handle allocator.
//
//   channel   direction  handshake     payload
//   in_req    input      valid/ready   cmd, handle_slot, handle_generation, in_use
//   out_rsp   output     valid/ready   status, out_slot, out_generation
//
// Each item reads the generation table and the free stack into registers, then,
// once the output is free, decides, writes both memories and loads the result.
// Both memories have a single port, so a new item is taken only after the
// previous one has written back. Reset clears the sequencer, the stack depth and
// the used-slot count; table entries above the used-slot count are never used.
// A stalled result holds in the output register while the next item is read in.
`timescale 1ns / 1ps
module generational_handle_allocator #(
  parameter int SLOTS    = 64,
  parameter int GEN_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  gha_req_if.sink   in_req,
  gha_rsp_if.source out_rsp
);
  import gha_pkg::*;

  gha_cmd_t ctrl_cmd;

  gha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (ctrl_cmd)
  );

  gha_dpath #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (ctrl_cmd),
    .in_cmd               (in_req.cmd),
    .in_handle_slot       (in_req.handle_slot),
    .in_handle_generation (in_req.handle_generation),
    .in_in_use            (in_req.in_use),
    .out_status           (out_rsp.status),
    .out_slot             (out_rsp.out_slot),
    .out_generation       (out_rsp.out_generation)
  );

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("item accepted while previous item still executing");

  a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.exec |=> out_rsp.valid)
    else $error("executed item produced no result");

  a_load_exec_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl_cmd.load && ctrl_cmd.exec))
    else $error("load and execute issued together");

  a_valid_rise_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_rsp.valid) |-> $past(ctrl_cmd.exec))
    else $error("result valid without execution");

endmodule

// ===== design/gha_ctrl.sv =====
// Controller: two-state sequencer and result-valid flag.
`timescale 1ns / 1ps
module gha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gha_pkg::gha_cmd_t cmd
);
  import gha_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = !out_valid_r || out_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/gha_dpath.sv =====
// Datapath: generation table, free stack, counters and result register.
`timescale 1ns / 1ps
module gha_dpath #(
  parameter int   SLOTS    = 64,
  parameter int   GEN_BITS = 16,
  localparam int  SLOT_W   = $clog2(SLOTS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gha_pkg::gha_cmd_t               cmd,
  input  logic [gha_pkg::CMD_W-1:0]       in_cmd,
  input  logic [SLOT_W-1:0]               in_handle_slot,
  input  logic [GEN_BITS-1:0]             in_handle_generation,
  input  logic                            in_in_use,
  output logic [gha_pkg::STATUS_W-1:0]    out_status,
  output logic [SLOT_W-1:0]               out_slot,
  output logic [GEN_BITS-1:0]             out_generation
);
  import gha_pkg::*;

  localparam int CNT_W = SLOT_W + 1;
  localparam int ENT_W = GEN_BITS + 1;
  localparam int STK_W = SLOT_W + GEN_BITS;

  // generation table entry: {occupied, generation}; stack entry: {slot, generation}
  logic [ENT_W-1:0] gen_mem [SLOTS];
  logic [STK_W-1:0] stk_mem [SLOTS];

  logic [ENT_W-1:0]    gen_rd_r;
  logic [STK_W-1:0]    stk_rd_r;
  logic [CMD_W-1:0]    req_cmd_r;
  logic [SLOT_W-1:0]   req_slot_r;
  logic [GEN_BITS-1:0] req_gen_r;
  logic                req_busy_r;

  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0] hw_r, hw_nxt;

  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [GEN_BITS-1:0] gen_r, gen_nxt;

  logic                gen_we;
  logic [SLOT_W-1:0]   gen_wa;
  logic [ENT_W-1:0]    gen_wd;
  logic                stk_we;
  logic [STK_W-1:0]    stk_wd;
  logic [SLOT_W-1:0]   stk_ra;

  logic                cur;
  logic [GEN_BITS-1:0] gen_inc;
  logic [GEN_BITS-1:0] gen_new;

  assign stk_ra = SLOT_W'(free_cnt_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gen_rd_r   <= gen_mem[in_handle_slot];
      stk_rd_r   <= stk_mem[stk_ra];
      req_cmd_r  <= in_cmd;
      req_slot_r <= in_handle_slot;
      req_gen_r  <= in_handle_generation;
      req_busy_r <= in_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_we) gen_mem[gen_wa] <= gen_wd;
    if (stk_we) stk_mem[free_cnt_r[SLOT_W-1:0]] <= stk_wd;
  end

  assign cur = (req_gen_r != '0) && ({1'b0, req_slot_r} < hw_r) &&
               gen_rd_r[GEN_BITS] && (gen_rd_r[GEN_BITS-1:0] == req_gen_r);

  assign gen_inc = gen_rd_r[GEN_BITS-1:0] + GEN_BITS'(1);
  assign gen_new = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

  always_comb begin
    free_cnt_nxt = free_cnt_r;
    hw_nxt       = hw_r;
    status_nxt   = ST_OK;
    slot_nxt     = req_slot_r;
    gen_nxt      = req_gen_r;
    gen_we       = 1'b0;
    gen_wa       = req_slot_r;
    gen_wd       = {1'b0, gen_new};
    stk_we       = 1'b0;
    stk_wd       = {req_slot_r, gen_new};
    unique case (req_cmd_r)
      CMD_ALLOC: begin
        priority if (free_cnt_r != '0) begin
          free_cnt_nxt = free_cnt_r - CNT_W'(1);
          slot_nxt     = stk_rd_r[STK_W-1:GEN_BITS];
          gen_nxt      = stk_rd_r[GEN_BITS-1:0];
          gen_we       = 1'b1;
          gen_wa       = stk_rd_r[STK_W-1:GEN_BITS];
          gen_wd       = {1'b1, stk_rd_r[GEN_BITS-1:0]};
        end else if (hw_r == CNT_W'(SLOTS)) begin
          status_nxt = ST_EXHAUSTED;
          slot_nxt   = '0;
          gen_nxt    = '0;
        end else begin
          hw_nxt   = hw_r + CNT_W'(1);
          slot_nxt = hw_r[SLOT_W-1:0];
          gen_nxt  = GEN_BITS'(1);
          gen_we   = 1'b1;
          gen_wa   = hw_r[SLOT_W-1:0];
          gen_wd   = {1'b1, GEN_BITS'(1)};
        end
      end
      CMD_FREE: begin
        priority if (!cur) begin
          status_nxt = ST_STALE;
        end else if (req_busy_r) begin
          status_nxt = ST_BUSY;
        end else begin
          gen_we = 1'b1;
          if (free_cnt_r < CNT_W'(SLOTS)) begin
            stk_we       = 1'b1;
            free_cnt_nxt = free_cnt_r + CNT_W'(1);
          end
        end
      end
      CMD_LOOKUP: status_nxt = cur ? ST_OK : ST_STALE;
      default:    status_nxt = cur ? ST_OK : ST_STALE;
    endcase
    gen_we = gen_we && cmd.exec;
    stk_we = stk_we && cmd.exec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r <= '0;
      hw_r       <= '0;
    end else if (cmd.exec) begin
      free_cnt_r <= free_cnt_nxt;
      hw_r       <= hw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      gen_r    <= gen_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_slot       = slot_r;
  assign out_generation = gen_r;

endmodule
